### sv/bam_pkg.sv
package bam_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int FRAME_WIDTH = 32;
  localparam int PATTERN_TOP = 7;
  localparam int PATTERN_W   = PATTERN_TOP + 1;

  typedef enum logic [1:0] {
    KIND_HOST    = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_PATTERN = 2'd2,
    KIND_FREE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACT_PATTERN  = 2'd0,
    ACT_SEND     = 2'd1,
    ACT_DELIVER  = 2'd2,
    ACT_OVERFLOW = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CFG_NODE_PRIORITY     = 1'b0,
    CFG_SUBSCRIBED_LEVELS = 1'b1
  } cfg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ARB     = 6'b000010,
    ST_TX      = 6'b000100,
    ST_TRX     = 6'b001000,
    ST_RX      = 6'b010000,
    ST_BACKOFF = 6'b100000
  } state_e;

  // Thermometer pattern: bits zero through prio set.
  function automatic logic [PATTERN_W-1:0] own_pattern(input logic [2:0] prio);
    logic [PATTERN_W-1:0] pat;
    for (int i = 0; i < PATTERN_W; i++) begin
      pat[i] = (3'(i) <= prio);
    end
    return pat;
  endfunction

  function automatic logic arb_won(input logic [PATTERN_W-1:0] bits,
                                   input logic [2:0]           prio);
    logic [PATTERN_W-1:0] need;
    need = own_pattern(prio);
    return (bits & need) == need;
  endfunction

  // Popcount c of the pattern selects bit c-1 of the levels; an empty pattern never matches.
  function automatic logic is_subscribed(input logic [PATTERN_W-1:0] bits,
                                         input logic [7:0]           levels);
    logic [3:0] c;
    logic [3:0] cm1;
    c = '0;
    for (int i = 0; i < PATTERN_W; i++) begin
      c = c + {3'b000, bits[i]};
    end
    cm1 = c - 4'd1;
    return (c != 4'd0) && levels[cm1[2:0]];
  endfunction

endpackage

### sv/bus_arbitration_mac_fsm.sv
// Bus MAC controller with priority arbitration. One request enters on the slave
// side (tuser gives its kind: host frame, bus data frame, bus priority pattern or
// bus free) and at most one result leaves on the master side (tuser gives the
// action: pattern down, frame down, frame up, queue overflow). A request is taken
// in every cycle while tready is high: the whole state update, the 8-bit popcount
// and the arbitration compare sit between the state registers and the result
// register. A two-entry output buffer lets the block keep taking requests while
// one result waits; tready drops only when both entries are full. Host frames
// wait in a queue held in a RAM with a registered read; the entry at the queue
// head is prefetched every cycle, with a bypass for a frame written to that
// entry in the same cycle, so popping into the held frame need not wait for the
// RAM read. The queue needs no clearing pass after reset. Configuration must
// be written through cfg_we_i / cfg_idx_i / cfg_data_i while idle (unenforced).
module bus_arbitration_mac_fsm #(
  parameter int QUEUE_DEPTH = bam_pkg::QUEUE_DEPTH,
  parameter int FRAME_WIDTH = bam_pkg::FRAME_WIDTH,
  localparam int TW = ((bam_pkg::PATTERN_W + FRAME_WIDTH + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration write port
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  // request side
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [TW-1:0] s_tdata,   // bus_bits_in [7:0], frame_in, zero padding
  input  logic [1:0]    s_tuser,   // kind
  // result side
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [TW-1:0] m_tdata,   // bus_bits_out [7:0], frame_out, zero padding
  output logic [1:0]    m_tuser    // action
);

  localparam int PW = bam_pkg::PATTERN_W;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;

  // configuration
  logic [2:0] node_prio_q;
  logic [7:0] sub_levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_prio_q  <= '0;
      sub_levels_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bam_pkg::cfg_idx_e'(cfg_idx_i))
        bam_pkg::CFG_NODE_PRIORITY:     node_prio_q  <= cfg_data_i[2:0];
        bam_pkg::CFG_SUBSCRIBED_LEVELS: sub_levels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request fields
  logic                   in_acc;
  bam_pkg::kind_e         kind;
  logic [PW-1:0]          bits_in;
  logic [FRAME_WIDTH-1:0] frame_in;

  assign in_acc   = s_tvalid && s_tready;
  assign kind     = bam_pkg::kind_e'(s_tuser);
  assign bits_in  = s_tdata[PW-1:0];
  assign frame_in = s_tdata[PW+FRAME_WIDTH-1:PW];

  // controller state
  bam_pkg::state_e        state_q, state_d, state_cur;
  logic                   held_v_q, held_v_d;
  logic [FRAME_WIDTH-1:0] held_q, held_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;

  // queue RAM and head prefetch
  logic                   wr_en;
  logic [AW-1:0]          tail;
  logic [SW-1:0]          tail_sum;
  logic [AW-1:0]          head_nxt;
  logic [FRAME_WIDTH-1:0] ram_rdata;
  logic                   byp_q;
  logic [FRAME_WIDTH-1:0] byp_data_q;
  logic [FRAME_WIDTH-1:0] head_frame;

  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : AW'(tail_sum);
  assign head_nxt = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);

  bam_ram #(
    .WIDTH (FRAME_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail),
    .wdata_i (frame_in),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  // The RAM returns the entry before this cycle's write; take the write data
  // instead when it lands on the entry being prefetched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_en && (tail == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= frame_in;
  end

  assign head_frame = byp_q ? byp_data_q : ram_rdata;

  // result of this request
  logic                   res_v;
  bam_pkg::action_e       res_act;
  logic [PW-1:0]          res_bits;
  logic [FRAME_WIDTH-1:0] res_frame;

  // Unused state codes fall back to idle.
  always_comb begin
    unique case (state_q)
      bam_pkg::ST_IDLE, bam_pkg::ST_ARB, bam_pkg::ST_TX,
      bam_pkg::ST_TRX, bam_pkg::ST_RX, bam_pkg::ST_BACKOFF: state_cur = state_q;
      default: state_cur = bam_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    state_d   = state_cur;
    held_v_d  = held_v_q;
    held_d    = held_q;
    head_d    = head_q;
    count_d   = count_q;
    wr_en     = 1'b0;
    res_v     = 1'b0;
    res_act   = bam_pkg::ACT_PATTERN;
    res_bits  = '0;
    res_frame = '0;

    if (in_acc) begin
      unique case (kind)
        bam_pkg::KIND_HOST: begin
          // full queue: drop the frame and flag it
          if (count_q >= CW'(QUEUE_DEPTH)) begin
            res_v   = 1'b1;
            res_act = bam_pkg::ACT_OVERFLOW;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        bam_pkg::KIND_DATA: begin
          if (state_cur == bam_pkg::ST_TX || state_cur == bam_pkg::ST_TRX) begin
            held_v_d = 1'b0;
          end
          if (state_cur == bam_pkg::ST_TRX || state_cur == bam_pkg::ST_RX) begin
            res_v     = 1'b1;
            res_act   = bam_pkg::ACT_DELIVER;
            res_frame = frame_in;
          end
          state_d = bam_pkg::ST_BACKOFF;
        end
        bam_pkg::KIND_PATTERN: begin
          if (state_cur == bam_pkg::ST_IDLE) begin
            state_d = bam_pkg::is_subscribed(bits_in, sub_levels_q) ? bam_pkg::ST_RX
                                                                    : bam_pkg::ST_BACKOFF;
          end else if (state_cur == bam_pkg::ST_ARB) begin
            if (bam_pkg::arb_won(bits_in, node_prio_q)) begin
              state_d   = bam_pkg::is_subscribed(bits_in, sub_levels_q) ? bam_pkg::ST_TRX
                                                                        : bam_pkg::ST_TX;
              res_v     = 1'b1;
              res_act   = bam_pkg::ACT_SEND;
              res_frame = held_q;
            end else begin
              state_d = bam_pkg::is_subscribed(bits_in, sub_levels_q) ? bam_pkg::ST_RX
                                                                      : bam_pkg::ST_BACKOFF;
            end
          end
        end
        bam_pkg::KIND_FREE: begin
          if (state_cur == bam_pkg::ST_ARB || state_cur == bam_pkg::ST_BACKOFF) begin
            state_d = bam_pkg::ST_IDLE;
          end
        end
        default: ;
      endcase

      // Back in idle: pull the head frame if none is held, then arbitrate if one is held.
      if (state_d == bam_pkg::ST_IDLE) begin
        if (!held_v_d && (count_d != '0)) begin
          // an empty queue means the head entry is the one written just now
          held_d   = (count_q == '0) ? frame_in : head_frame;
          head_d   = head_nxt;
          count_d  = count_d - CW'(1);
          held_v_d = 1'b1;
        end
        if (held_v_d) begin
          state_d = bam_pkg::ST_ARB;
          // an overflow in the same request suppresses the pattern
          if (!res_v) begin
            res_v    = 1'b1;
            res_act  = bam_pkg::ACT_PATTERN;
            res_bits = bam_pkg::own_pattern(node_prio_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bam_pkg::ST_IDLE;
      held_v_q <= 1'b0;
      head_q   <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      held_v_q <= held_v_d;
      head_q   <= head_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  // Two-entry output buffer: the main register faces the bus, the skid entry
  // catches a result that arrives while the main one is stalled.
  logic                   out_v_q, skid_v_q;
  logic                   out_take;
  logic [1:0]             out_act_q, skid_act_q;
  logic [PW-1:0]          out_bits_q, skid_bits_q;
  logic [FRAME_WIDTH-1:0] out_frame_q, skid_frame_q;

  assign out_take = m_tvalid && m_tready;
  assign s_tready = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= res_v;
      end
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_v_q) begin
      if (skid_v_q) begin
        out_act_q   <= skid_act_q;
        out_bits_q  <= skid_bits_q;
        out_frame_q <= skid_frame_q;
      end else begin
        out_act_q   <= res_act;
        out_bits_q  <= res_bits;
        out_frame_q <= res_frame;
      end
    end else if (res_v) begin
      skid_act_q   <= res_act;
      skid_bits_q  <= res_bits;
      skid_frame_q <= res_frame;
    end
  end

  assign m_tvalid = out_v_q;
  assign m_tuser  = out_act_q;
  // zero-extend into the byte padding
  assign m_tdata  = TW'({out_frame_q, out_bits_q});

endmodule

### sv/bam_ram.sv
module bam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bam_checker.sv
module bam_checker #(
  parameter int FRAME_WIDTH = bam_pkg::FRAME_WIDTH,
  localparam int TW = ((bam_pkg::PATTERN_W + FRAME_WIDTH + 7) / 8) * 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [TW-1:0] m_tdata,
  input logic [1:0]    m_tuser
);

  localparam int PW = bam_pkg::PATTERN_W;

  logic [PW-1:0] bits_out;
  logic [TW-1:0] no_bits;

  assign bits_out = m_tdata[PW-1:0];
  assign no_bits  = m_tdata & ~TW'({PW{1'b1}});

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // only a full output buffer stops requests
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> m_tvalid)
    else $error("requests refused with an empty output");

  // pattern down carries a non-empty thermometer and no frame
  a_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == bam_pkg::ACT_PATTERN) |->
      bits_out[0] && ((bits_out & (bits_out + PW'(1))) == '0) && (no_bits == '0))
    else $error("malformed arbitration pattern");

  // frames carry no pattern bits
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && ((m_tuser == bam_pkg::ACT_SEND) || (m_tuser == bam_pkg::ACT_DELIVER)) |->
      bits_out == '0)
    else $error("pattern bits set on a frame");

  // overflow carries nothing
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == bam_pkg::ACT_OVERFLOW) |-> m_tdata == '0)
    else $error("overflow with payload");

endmodule

bind bus_arbitration_mac_fsm bam_checker #(.FRAME_WIDTH(FRAME_WIDTH)) u_bam_checker (.*);
